// ===== src/mips_integer_execute_unit_top_assert.svh =====
// Assertion macros shared by the checker of the execute unit.
`ifndef MIPS_INTEGER_EXECUTE_UNIT_TOP_ASSERT_SVH
`define MIPS_INTEGER_EXECUTE_UNIT_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define MIEU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define MIEU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== src/mieu_pkg.sv =====
// Package with the opcodes, function codes and status codes of the execute unit.
package mieu_pkg;
	localparam int XLEN = 32;
	localparam int RIDX = 5;
	localparam int NREGS = 32;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_OVF   = 2'd1,
		ST_UNSUP = 2'd2
	} status_t;

	localparam logic [5:0] OP_SPECIAL = 6'd0;
	localparam logic [5:0] OP_ADDI    = 6'd8;
	localparam logic [5:0] OP_ADDIU   = 6'd9;
	localparam logic [5:0] OP_SLTI    = 6'd10;
	localparam logic [5:0] OP_SLTIU   = 6'd11;
	localparam logic [5:0] OP_ANDI    = 6'd12;
	localparam logic [5:0] OP_ORI     = 6'd13;
	localparam logic [5:0] OP_XORI    = 6'd14;
	localparam logic [5:0] OP_LUI     = 6'd15;

	localparam logic [5:0] FN_SLL   = 6'd0;
	localparam logic [5:0] FN_SRL   = 6'd2;
	localparam logic [5:0] FN_SRA   = 6'd3;
	localparam logic [5:0] FN_SLLV  = 6'd4;
	localparam logic [5:0] FN_SRLV  = 6'd6;
	localparam logic [5:0] FN_SRAV  = 6'd7;
	localparam logic [5:0] FN_MFHI  = 6'd16;
	localparam logic [5:0] FN_MTHI  = 6'd17;
	localparam logic [5:0] FN_MFLO  = 6'd18;
	localparam logic [5:0] FN_MTLO  = 6'd19;
	localparam logic [5:0] FN_MULT  = 6'd24;
	localparam logic [5:0] FN_MULTU = 6'd25;
	localparam logic [5:0] FN_DIV   = 6'd26;
	localparam logic [5:0] FN_DIVU  = 6'd27;
	localparam logic [5:0] FN_ADD   = 6'd32;
	localparam logic [5:0] FN_ADDU  = 6'd33;
	localparam logic [5:0] FN_SUB   = 6'd34;
	localparam logic [5:0] FN_SUBU  = 6'd35;
	localparam logic [5:0] FN_AND   = 6'd36;
	localparam logic [5:0] FN_OR    = 6'd37;
	localparam logic [5:0] FN_XOR   = 6'd38;
	localparam logic [5:0] FN_SLT   = 6'd42;
	localparam logic [5:0] FN_SLTU  = 6'd43;
endpackage

// ===== src/mips_integer_execute_unit_top.sv =====
// Top level of the MIPS integer execute unit with register file, HI and LO.
//
// Usage: instruction words enter on the s_axis channel (tdata = instr_word) and one
// result word leaves on m_axis per instruction. The unit works on one instruction at
// a time: s_axis_tready is high only while the unit is idle and its output register
// is empty, so the next word is taken once the previous result has been taken.
// Each instruction reads its two source registers from the register file memory in
// S_READ, then runs a sequencer around a 33-bit ALU adder/subtractor and a separate
// 33-bit adder and subtractor for the multiply and divide loops. ALU, shift and move
// forms and a divide by zero pass through read and execute; MULT/MULTU then run 32
// shift-add steps plus sign fixup and DIV/DIVU 32 restoring steps plus sign fixup.
// A new word is taken only after the result handoff and the return to idle.
// Reset (arst_n low) clears HI, LO, all control state and all 32 registers at once:
// register validity is kept in flip-flops, and a register never written reads zero.
// When the receiver stalls (m_axis_tready low) the result stays in the output register
// and no new word is taken until it is delivered.
module mips_integer_execute_unit_top
	import mieu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] instr_word
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [1:0] status, [2] reg_written, [7:3] dest_index, [39:8] dest_value,
	// [71:40] hi_now, [103:72] lo_now
	output logic [103:0] m_axis_tdata
);
	typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_FIX, S_OUT} state_t;

	state_t state_q;
	logic [XLEN-1:0] rf_mem [NREGS];
	logic [NREGS-1:0] rf_valid_q;
	logic [XLEN-1:0] rda_q, rdb_q;
	logic [31:0] instr_q;
	logic [XLEN-1:0] hi_q, lo_q;
	logic [XLEN-1:0] acc_q, mq_q, opb_q; // remainder/high, quotient/low, operand
	logic [5:0] cnt_q;
	logic neg_q, negr_q;
	logic [1:0] st_q;
	logic wr_q;
	logic [RIDX-1:0] dst_q;
	logic [XLEN-1:0] val_q;
	logic out_v_q;

	logic [5:0] op, fn;
	logic [RIDX-1:0] rs, rt, rd, sh;
	logic [XLEN-1:0] a, b, imm_z, imm_s;
	assign op = instr_q[31:26];
	assign rs = instr_q[25:21];
	assign rt = instr_q[20:16];
	assign rd = instr_q[15:11];
	assign sh = instr_q[10:6];
	assign fn = instr_q[5:0];
	assign a = rf_valid_q[rs] ? rda_q : '0;
	assign b = rf_valid_q[rt] ? rdb_q : '0;
	assign imm_z = {16'd0, instr_q[15:0]};
	assign imm_s = {{16{instr_q[15]}}, instr_q[15:0]};

	// Combinational execute: one add/subtract, one shift and logic.
	logic [1:0] ex_st;
	logic ex_wr;
	logic [RIDX-1:0] ex_dst;
	logic [XLEN-1:0] ex_val, ex_opb, ex_sum;
	logic ex_sub, ex_long, ex_mthi, ex_mtlo;
	logic [XLEN:0] ex_add;
	logic [RIDX-1:0] shamt;
	logic signed [XLEN:0] sra_src;
	logic ovf, lts, ltu;

	always_comb begin
		ex_sub = 1'b0;
		ex_opb = b;
		if (op == OP_SPECIAL) begin
			ex_sub = (fn == FN_SUB) || (fn == FN_SUBU) || (fn == FN_SLT) || (fn == FN_SLTU);
		end else begin
			ex_opb = imm_s;
			ex_sub = (op == OP_SLTI) || (op == OP_SLTIU);
		end
	end
	assign ex_add = {1'b0, a} + (ex_sub ? {1'b0, ~ex_opb} : {1'b0, ex_opb}) + {32'd0, ex_sub};
	assign ex_sum = ex_add[XLEN-1:0];
	assign ovf = ex_sub ? (((a ^ ex_opb) & (a ^ ex_sum)) >> (XLEN-1)) != 0
		: (((a ^ ex_sum) & (ex_opb ^ ex_sum)) >> (XLEN-1)) != 0;
	assign ltu = !ex_add[XLEN];
	assign lts = (a[XLEN-1] != ex_opb[XLEN-1]) ? a[XLEN-1] : ex_sum[XLEN-1];
	assign shamt = fn[2] ? a[RIDX-1:0] : sh;
	assign sra_src = {b[XLEN-1], b};

	always_comb begin
		ex_st = ST_DONE;
		ex_wr = 1'b1;
		ex_val = '0;
		ex_long = 1'b0;
		ex_mthi = 1'b0;
		ex_mtlo = 1'b0;
		ex_dst = (op == OP_SPECIAL) ? rd : rt;
		if (op == OP_SPECIAL) begin
			unique case (fn)
				FN_SLL, FN_SLLV: ex_val = b << shamt;
				FN_SRL, FN_SRLV: ex_val = b >> shamt;
				FN_SRA, FN_SRAV: ex_val = XLEN'(sra_src >>> shamt);
				FN_MFHI: ex_val = hi_q;
				FN_MFLO: ex_val = lo_q;
				FN_MTHI: begin ex_wr = 1'b0; ex_mthi = 1'b1; end
				FN_MTLO: begin ex_wr = 1'b0; ex_mtlo = 1'b1; end
				FN_MULT, FN_MULTU, FN_DIV, FN_DIVU: begin ex_wr = 1'b0; ex_long = 1'b1; end
				FN_ADD, FN_SUB: begin
					if (ovf) begin ex_st = ST_OVF; ex_wr = 1'b0; end
					else ex_val = ex_sum;
				end
				FN_ADDU, FN_SUBU: ex_val = ex_sum;
				FN_AND: ex_val = a & b;
				FN_OR:  ex_val = a | b;
				FN_XOR: ex_val = a ^ b;
				FN_SLT:  ex_val = {31'd0, lts};
				FN_SLTU: ex_val = {31'd0, ltu};
				default: begin ex_st = ST_UNSUP; ex_wr = 1'b0; end
			endcase
		end else begin
			unique case (op)
				OP_ADDI: begin
					if (ovf) begin ex_st = ST_OVF; ex_wr = 1'b0; end
					else ex_val = ex_sum;
				end
				OP_ADDIU: ex_val = ex_sum;
				OP_SLTI:  ex_val = {31'd0, lts};
				OP_SLTIU: ex_val = {31'd0, ltu};
				OP_ANDI:  ex_val = a & imm_z;
				OP_ORI:   ex_val = a | imm_z;
				OP_XORI:  ex_val = a ^ imm_z;
				OP_LUI:   ex_val = {instr_q[15:0], 16'd0};
				default: begin ex_st = ST_UNSUP; ex_wr = 1'b0; end
			endcase
		end
		if (!ex_wr || ex_dst == '0) begin
			ex_wr = 1'b0;
			ex_dst = '0;
			ex_val = '0;
		end
	end

	// Separate 33-bit adder and subtractor for the multiply and divide loops.
	logic [XLEN:0] mul_sum;
	logic [XLEN:0] div_diff;
	logic [XLEN:0] div_rem;
	assign mul_sum = {1'b0, acc_q} + (mq_q[0] ? {1'b0, opb_q} : '0);
	assign div_rem = {acc_q, mq_q[XLEN-1]};
	assign div_diff = div_rem - {1'b0, opb_q};

	logic is_div, sgn;
	assign is_div = fn[1];
	assign sgn = !fn[0];

	// Source registers are read from the held instruction during S_READ.
	always_ff @(posedge clk) begin
		rda_q <= rf_mem[rs];
		rdb_q <= rf_mem[rt];
		if (state_q == S_EXEC && ex_wr) begin
			rf_mem[ex_dst] <= ex_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rf_valid_q <= '0;
			hi_q <= '0;
			lo_q <= '0;
			out_v_q <= 1'b0;
			instr_q <= '0;
			acc_q <= '0;
			mq_q <= '0;
			opb_q <= '0;
			cnt_q <= '0;
			neg_q <= 1'b0;
			negr_q <= 1'b0;
			st_q <= ST_DONE;
			wr_q <= 1'b0;
			dst_q <= '0;
			val_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						instr_q <= s_axis_tdata;
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_EXEC;
				S_EXEC: begin
					st_q <= ex_st;
					wr_q <= ex_wr;
					dst_q <= ex_dst;
					val_q <= ex_val;
					if (ex_wr) rf_valid_q[ex_dst] <= 1'b1;
					if (ex_mthi) hi_q <= a;
					if (ex_mtlo) lo_q <= a;
					if (ex_long) begin
						// Work on magnitudes for the signed forms.
						neg_q <= sgn && (a[XLEN-1] != b[XLEN-1]);
						negr_q <= sgn && a[XLEN-1];
						mq_q <= (sgn && a[XLEN-1]) ? -a : a;
						opb_q <= (sgn && b[XLEN-1]) ? -b : b;
						acc_q <= '0;
						cnt_q <= '0;
						if (is_div && b == '0) begin
							lo_q <= '1;
							hi_q <= a;
							state_q <= S_OUT;
							out_v_q <= 1'b1;
						end else begin
							state_q <= is_div ? S_DIV : S_MUL;
						end
					end else begin
						state_q <= S_OUT;
						out_v_q <= 1'b1;
					end
				end
				S_MUL: begin
					// Shift-add, low product bits move into mq_q.
					acc_q <= mul_sum[XLEN:1];
					mq_q <= {mul_sum[0], mq_q[XLEN-1:1]};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) state_q <= S_FIX;
				end
				S_DIV: begin
					// Restoring step; quotient bits shift into mq_q.
					if (!div_diff[XLEN]) begin
						acc_q <= div_diff[XLEN-1:0];
						mq_q <= {mq_q[XLEN-2:0], 1'b1};
					end else begin
						acc_q <= div_rem[XLEN-1:0];
						mq_q <= {mq_q[XLEN-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) state_q <= S_FIX;
				end
				S_FIX: begin
					if (is_div) begin
						lo_q <= neg_q ? -mq_q : mq_q;
						hi_q <= negr_q ? -acc_q : acc_q;
					end else begin
						{hi_q, lo_q} <= neg_q ? -{acc_q, mq_q} : {acc_q, mq_q};
					end
					state_q <= S_OUT;
					out_v_q <= 1'b1;
				end
				S_OUT: begin
					if (m_axis_tready) begin
						out_v_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {lo_q, hi_q, val_q, dst_q, wr_q, st_q};
endmodule

// ===== src/mips_integer_execute_unit_top_checker.sv =====
// Port-level checker for the execute unit and its bind statement.
`include "mips_integer_execute_unit_top_assert.svh"
module mips_integer_execute_unit_top_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [103:0] m_axis_tdata
);
	`MIEU_ASSERT_IMP(a_one_at_a_time, clk, arst_n, m_axis_tvalid, !s_axis_tready, "input taken while result pending")
	`MIEU_ASSERT_NEXT(a_accept_busy, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready after accept")
	`MIEU_ASSERT_IMP(a_status_code, clk, arst_n, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3, "illegal status")
	`MIEU_ASSERT_IMP(a_no_write_zero, clk, arst_n, m_axis_tvalid && !m_axis_tdata[2], m_axis_tdata[39:3] == 37'd0, "write fields set without write")
	`MIEU_ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
endmodule

bind mips_integer_execute_unit_top mips_integer_execute_unit_top_checker u_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
